### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers for the text cell renderer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TMCR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TMCR_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/tmcr_pkg.sv
// ----------------------------------------------------------------------------
// tmcr_pkg
// Types, codes and constants shared by the text cell renderer modules.
// ----------------------------------------------------------------------------
package tmcr_pkg;

  localparam int PAGE_AW    = 13;
  localparam int PAGE_DEPTH = 8192;

  localparam logic [12:0] PAL_BASE  = 13'h0FA0;
  localparam logic [12:0] PAL_END   = 13'h0FC0;
  localparam logic [12:0] FONT_BASE = 13'h1000;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_RENDER = 1'b1
  } action_e;

  typedef enum logic {
    KIND_GLYPH  = 1'b0,
    KIND_REDRAW = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_CELL   = 2'd1,
    RES_REDRAW = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    CFG_VIDEO_MODE   = 3'd0,
    CFG_CURSOR_COL   = 3'd1,
    CFG_CURSOR_ROW   = 3'd2,
    CFG_BLINK_PHASE  = 3'd3,
    CFG_DOUBLE_SCALE = 3'd4,
    CFG_OFFSET_X     = 3'd5,
    CFG_OFFSET_Y     = 3'd6
  } cfg_reg_e;

  localparam logic [1:0] MODE_TEXT = 2'd0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CH,
    ST_AT,
    ST_FG0,
    ST_FG1,
    ST_BG0,
    ST_BG1,
    ST_ROW,
    ST_REDRAW
  } back_st_e;

  typedef struct packed {
    logic        action;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [6:0]  cell_col;
    logic [4:0]  cell_row;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [23:0] color0;
    logic [23:0] color1;
    logic [23:0] color2;
    logic [23:0] color3;
    logic [23:0] color4;
    logic [23:0] color5;
    logic [23:0] color6;
    logic [23:0] color7;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [9:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0] video_mode;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       blink_phase;
    logic       double_scale;
    logic [9:0] offset_x;
    logic [9:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic        do_write;
    res_e        res;
    logic [12:0] wr_addr;
    logic [7:0]  wr_data;
    logic [12:0] base;
    logic [6:0]  col;
    logic [5:0]  row;
  } q_entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // {r,g,b} nibbles to 24-bit colour, each nibble in the top of its byte
  function automatic logic [23:0] rgb_to_24(input logic [11:0] rgb);
    return {rgb[11:8], 4'h0, rgb[7:4], 4'h0, rgb[3:0], 4'h0};
  endfunction

endpackage

### design/tmcr_stream_if.sv
// ----------------------------------------------------------------------------
// tmcr_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface tmcr_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/tmcr_ram.sv
// ----------------------------------------------------------------------------
// tmcr_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tmcr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### design/tmcr_front.sv
// ----------------------------------------------------------------------------
// tmcr_front
// Accepts items, splits a cell offset into column and row, classifies the
// result and pushes a command into the queue.
// ----------------------------------------------------------------------------
module tmcr_front #(
  parameter int TEXT_COLS  = 80,
  parameter int TEXT_LINES = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmcr_pkg::in_item_t  in_payload,
  input  tmcr_pkg::back_stat_t stat,
  input  logic [1:0]          video_mode,
  output logic                q_push,
  output tmcr_pkg::q_entry_t  q_data,
  input  logic                q_full
);

  // reciprocal of TEXT_COLS, exact for 11-bit cell numbers
  localparam int DivS    = 18;
  localparam int DivM    = (2**DivS + TEXT_COLS - 1) / TEXT_COLS;
  localparam int ProdW   = 30;
  localparam int CellEnd = 2 * TEXT_COLS * TEXT_LINES;

  logic               busy_r, busy_nxt;
  tmcr_pkg::in_item_t item_r;
  logic [ProdW-1:0]   prod_r, prod_nxt;

  logic               acc;
  logic               text_mode;
  logic [5:0]         q6;
  logic [10:0]        colw;
  logic [12:0]        rbase;
  logic               in_area, in_pal, in_font;
  logic               need;
  tmcr_pkg::q_entry_t ent;

  always_comb begin
    in_ready  = !busy_r && !stat.clearing;
    acc       = in_valid && in_ready;
    prod_nxt  = ProdW'(in_payload.addr[11:1]) * ProdW'(DivM);
    text_mode = (video_mode == tmcr_pkg::MODE_TEXT);

    q6    = prod_r[DivS +: 6];
    colw  = item_r.addr[11:1] - 11'(11'(q6) * 11'(TEXT_COLS));
    rbase = 13'(13'(item_r.cell_row) * 13'(TEXT_COLS)) + 13'(item_r.cell_col);

    in_area = (int'(item_r.addr) < CellEnd) && (item_r.addr < tmcr_pkg::PAL_BASE);
    in_pal  = (item_r.addr >= tmcr_pkg::PAL_BASE) && (item_r.addr < tmcr_pkg::PAL_END);
    in_font = (item_r.addr >= tmcr_pkg::FONT_BASE);

    ent         = '0;
    ent.wr_addr = item_r.addr;
    ent.wr_data = item_r.data;
    ent.res     = tmcr_pkg::RES_NONE;
    if (item_r.action == tmcr_pkg::ACT_WRITE) begin
      ent.do_write = 1'b1;
      ent.base     = {item_r.addr[12:1], 1'b0};
      ent.col      = colw[6:0];
      ent.row      = q6;
      if (text_mode && in_area) begin
        ent.res = tmcr_pkg::RES_CELL;
      end else if (text_mode && (in_pal || in_font)) begin
        ent.res = tmcr_pkg::RES_REDRAW;
      end
    end else begin
      ent.do_write = 1'b0;
      ent.base     = {rbase[11:0], 1'b0};
      ent.col      = item_r.cell_col;
      ent.row      = {1'b0, item_r.cell_row};
      if (text_mode) begin
        ent.res = tmcr_pkg::RES_CELL;
      end
    end

    need     = ent.do_write || (ent.res != tmcr_pkg::RES_NONE);
    q_push   = busy_r && need && !q_full;
    q_data   = ent;
    busy_nxt = acc || (busy_r && need && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= in_payload;
      prod_r <= prod_nxt;
    end
  end

endmodule

### design/tmcr_queue.sv
// ----------------------------------------------------------------------------
// tmcr_queue
// Two-entry command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tmcr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tmcr_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output tmcr_pkg::q_entry_t pop_data,
  output logic               empty
);

  tmcr_pkg::q_entry_t mem_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r, cnt_nxt;

  always_comb begin
    full     = (cnt_r == 2'd2);
    empty    = (cnt_r == 2'd0);
    pop_data = mem_r[rd_ptr_r];
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/tmcr_back.sv
// ----------------------------------------------------------------------------
// tmcr_back
// Owns the text page RAM: clears it after reset, stores bytes, fetches the
// character, attribute, palette and font bytes and emits glyph rows and redraw requests.
// ----------------------------------------------------------------------------
module tmcr_back #(
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmcr_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  tmcr_pkg::q_entry_t   q_data,
  output logic                 q_pop,
  output tmcr_pkg::back_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tmcr_pkg::out_item_t  out_payload
);

  localparam int YCW = $clog2(GLYPH_HEIGHT + 1);

  tmcr_pkg::back_st_e  st_r, st_nxt;
  logic [12:0]         clr_r, clr_nxt;
  tmcr_pkg::q_entry_t  cur_r, cur_nxt;
  logic [7:0]          ch_r, ch_nxt;
  logic [7:0]          attr_r, attr_nxt;
  logic [11:0]         fg_r, fg_nxt;
  logic [11:0]         bg_r, bg_nxt;
  logic [10:0]         ybase_r, ybase_nxt;
  logic [YCW-1:0]      iss_r, iss_nxt;
  logic [3:0]          emit_y_r, emit_y_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  tmcr_pkg::out_item_t out_r, out_nxt;

  logic        ram_en, ram_we;
  logic [12:0] ram_addr;
  logic [7:0]  ram_wdata, ram_rdata;

  logic        slot_free, emit, issue, inv, on_cursor, sel;
  logic [10:0] py_raw;
  logic [11:0] rgb;
  logic [23:0] colors [8];

  tmcr_ram #(
    .DATA_W(8),
    .DEPTH (tmcr_pkg::PAGE_DEPTH)
  ) u_page (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    ch_nxt        = ch_r;
    attr_nxt      = attr_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    ybase_nxt     = ybase_r;
    iss_nxt       = iss_r;
    emit_y_nxt    = emit_y_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = cur_r.base;
    ram_wdata     = cur_r.wr_data;
    slot_free     = !out_valid_r || out_ready;
    emit          = 1'b0;
    issue         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    on_cursor = (cfg.cursor_col == cur_r.col) && ({1'b0, cfg.cursor_row} == cur_r.row);
    inv       = on_cursor && cfg.blink_phase && (emit_y_r >= 4'(GLYPH_HEIGHT - 2));
    py_raw    = ybase_r + 11'(emit_y_r);
    for (int x = 0; x < 8; x++) begin
      sel       = ram_rdata[7 - x] ^ inv;
      rgb       = sel ? fg_r : bg_r;
      colors[x] = tmcr_pkg::rgb_to_24(rgb);
    end

    unique case (st_r)
      tmcr_pkg::ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = 8'h00;
        clr_nxt   = clr_r + 13'd1;
        if (clr_r == 13'h1FFF) begin
          st_nxt = tmcr_pkg::ST_IDLE;
        end
      end
      tmcr_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_data;
          if (q_data.do_write) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = q_data.wr_addr;
            ram_wdata = q_data.wr_data;
          end
          unique case (q_data.res)
            tmcr_pkg::RES_CELL:   st_nxt = tmcr_pkg::ST_CH;
            tmcr_pkg::RES_REDRAW: st_nxt = tmcr_pkg::ST_REDRAW;
            default:              st_nxt = tmcr_pkg::ST_IDLE;
          endcase
        end
      end
      tmcr_pkg::ST_CH: begin
        ram_en    = 1'b1;
        ram_addr  = cur_r.base;
        ybase_nxt = 11'(11'(GLYPH_HEIGHT) * 11'(cur_r.row));
        st_nxt    = tmcr_pkg::ST_AT;
      end
      tmcr_pkg::ST_AT: begin
        ch_nxt   = ram_rdata;
        ram_en   = 1'b1;
        ram_addr = cur_r.base + 13'd1;
        st_nxt   = tmcr_pkg::ST_FG0;
      end
      tmcr_pkg::ST_FG0: begin
        attr_nxt = ram_rdata;
        ram_en   = 1'b1;
        ram_addr = tmcr_pkg::PAL_BASE + {8'd0, ram_rdata[3:0], 1'b0};
        st_nxt   = tmcr_pkg::ST_FG1;
      end
      tmcr_pkg::ST_FG1: begin
        fg_nxt[7:0] = ram_rdata;
        ram_en      = 1'b1;
        ram_addr    = tmcr_pkg::PAL_BASE + {8'd0, attr_r[3:0], 1'b1};
        st_nxt      = tmcr_pkg::ST_BG0;
      end
      tmcr_pkg::ST_BG0: begin
        fg_nxt[11:8] = ram_rdata[3:0];
        ram_en       = 1'b1;
        ram_addr     = tmcr_pkg::PAL_BASE + {8'd0, attr_r[7:4], 1'b0};
        st_nxt       = tmcr_pkg::ST_BG1;
      end
      tmcr_pkg::ST_BG1: begin
        bg_nxt[7:0] = ram_rdata;
        ram_en      = 1'b1;
        ram_addr    = tmcr_pkg::PAL_BASE + {8'd0, attr_r[7:4], 1'b1};
        iss_nxt     = '0;
        pend_nxt    = 1'b0;
        st_nxt      = tmcr_pkg::ST_ROW;
      end
      tmcr_pkg::ST_ROW: begin
        // first cycle here sees the background red byte
        if (iss_r == '0 && !pend_r) begin
          bg_nxt[11:8] = ram_rdata[3:0];
        end
        emit  = pend_r && slot_free;
        issue = (!pend_r || emit) && (iss_r < YCW'(GLYPH_HEIGHT));
        if (emit) begin
          out_valid_nxt   = 1'b1;
          out_nxt.kind    = tmcr_pkg::KIND_GLYPH;
          out_nxt.pixel_x = cfg.double_scale ? {cur_r.col, 4'd0}
                                             : 11'({cur_r.col, 3'd0}) + 11'(cfg.offset_x);
          out_nxt.pixel_y = cfg.double_scale ? {py_raw[9:0], 1'b0}
                                             : py_raw + 11'(cfg.offset_y);
          out_nxt.color0  = colors[0];
          out_nxt.color1  = colors[1];
          out_nxt.color2  = colors[2];
          out_nxt.color3  = colors[3];
          out_nxt.color4  = colors[4];
          out_nxt.color5  = colors[5];
          out_nxt.color6  = colors[6];
          out_nxt.color7  = colors[7];
          out_nxt.last    = (emit_y_r == 4'(GLYPH_HEIGHT - 1));
          if (emit_y_r == 4'(GLYPH_HEIGHT - 1)) begin
            st_nxt = tmcr_pkg::ST_IDLE;
          end
        end
        if (issue) begin
          ram_en     = 1'b1;
          ram_addr   = {1'b1, ch_r, 4'(iss_r)};
          emit_y_nxt = 4'(iss_r);
          iss_nxt    = iss_r + YCW'(1);
          pend_nxt   = 1'b1;
        end else if (emit) begin
          pend_nxt = 1'b0;
        end
      end
      tmcr_pkg::ST_REDRAW: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.kind  = tmcr_pkg::KIND_REDRAW;
          out_nxt.last  = 1'b1;
          st_nxt        = tmcr_pkg::ST_IDLE;
        end
      end
      default: st_nxt = tmcr_pkg::ST_IDLE;
    endcase

    stat.clearing = (st_r == tmcr_pkg::ST_CLEAR);
    out_valid     = out_valid_r;
    out_payload   = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tmcr_pkg::ST_CLEAR;
      clr_r       <= 13'd0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    ch_r     <= ch_nxt;
    attr_r   <= attr_nxt;
    fg_r     <= fg_nxt;
    bg_r     <= bg_nxt;
    ybase_r  <= ybase_nxt;
    emit_y_r <= emit_y_nxt;
    out_r    <= out_nxt;
  end

endmodule

### design/text_mode_cell_renderer_top.sv
// ----------------------------------------------------------------------------
// text_mode_cell_renderer_top
// Text page renderer: stores page bytes and turns cells into glyph rows.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      transfer when
//  in_ch    in   action, addr, data, cell_col, cell_row       valid & ready
//  out_ch   out  kind, pixel_x/y, color0..7, last             valid & ready
//  cfg_ch   in   idx (register), wdata                        valid & ready
//
//  A cell item passes, in order, the front register, the queue pop, six page
//  RAM reads for character, attribute and four palette bytes, the font reads
//  of the glyph rows and the output register. The back works on one cell at
//  a time, as the single-port page RAM takes its reads one after another.
//  A plain write is stored when the back pops it from the queue; a redraw
//  request passes the redraw state and the output register.
//  After reset all 8192 page bytes are cleared; in_ch.ready stays low.
//  A stalled out_ch holds the back; the two-entry queue lets the front
//  keep taking items meanwhile, until the queue is full.
// ----------------------------------------------------------------------------
module text_mode_cell_renderer_top #(
  parameter int TEXT_COLS    = 80,
  parameter int TEXT_LINES   = 25,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  tmcr_stream_if.sink   in_ch,
  tmcr_stream_if.source out_ch,
  tmcr_stream_if.sink   cfg_ch
);

  tmcr_pkg::cfg_t       cfg_r, cfg_nxt;
  tmcr_pkg::cfg_wr_t    cfg_wr;
  tmcr_pkg::back_stat_t stat;
  tmcr_pkg::q_entry_t   push_data, pop_data;
  logic                 q_push, q_pop, q_full, q_empty;
  logic                 front_ready, out_valid;
  tmcr_pkg::out_item_t  out_payload;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.payload;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_wr.idx)
        tmcr_pkg::CFG_VIDEO_MODE:   cfg_nxt.video_mode   = cfg_wr.wdata[1:0];
        tmcr_pkg::CFG_CURSOR_COL:   cfg_nxt.cursor_col   = cfg_wr.wdata[6:0];
        tmcr_pkg::CFG_CURSOR_ROW:   cfg_nxt.cursor_row   = cfg_wr.wdata[4:0];
        tmcr_pkg::CFG_BLINK_PHASE:  cfg_nxt.blink_phase  = cfg_wr.wdata[0];
        tmcr_pkg::CFG_DOUBLE_SCALE: cfg_nxt.double_scale = cfg_wr.wdata[0];
        tmcr_pkg::CFG_OFFSET_X:     cfg_nxt.offset_x     = cfg_wr.wdata;
        tmcr_pkg::CFG_OFFSET_Y:     cfg_nxt.offset_y     = cfg_wr.wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tmcr_front #(
    .TEXT_COLS (TEXT_COLS),
    .TEXT_LINES(TEXT_LINES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (front_ready),
    .in_payload(in_ch.payload),
    .stat      (stat),
    .video_mode(cfg_r.video_mode),
    .q_push    (q_push),
    .q_data    (push_data),
    .q_full    (q_full)
  );

  assign in_ch.ready = front_ready;

  tmcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  tmcr_back #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_payload(out_payload)
  );

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_payload;

endmodule

### design/tmcr_checker.sv
// ----------------------------------------------------------------------------
// tmcr_checker
// Port-level checks on the text cell renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmcr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tmcr_pkg::out_item_t out_payload
);

  // page clear must start right after reset, holding off input
  `TMCR_ASSERT_NORST(a_clear_after_reset, clk, !rst_n |=> !in_ready, "input taken during clear")

  `TMCR_ASSERT(a_redraw_last, clk, rst_n, out_valid && out_payload.kind |-> out_payload.last, "redraw without last")

  `TMCR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `TMCR_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_payload), "result changed while stalled")

endmodule

bind text_mode_cell_renderer_top tmcr_checker u_tmcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_payload(out_ch.payload)
);

### test/tb_text_mode_cell_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_mode_cell_renderer_top
// Self-checking bench for the text cell renderer. A scoreboard keeps its own
// copy of the text page and registers, expands every accepted page write or
// render into the glyph rows or redraw request it must cause, and compares
// each delivered result field by field. Stimulus mixes directed corner
// cases with phases of random palette, font and cell traffic under several
// register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

class text_page_scoreboard;
  localparam int COLS    = 80;
  localparam int LINES   = 25;
  localparam int GLYPH_H = 16;

  logic [7:0] page_mem [tmcr_pkg::PAGE_DEPTH];
  logic [1:0] video_mode;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic       blink_phase;
  logic       double_scale;
  logic [9:0] offset_x;
  logic [9:0] offset_y;

  tmcr_pkg::out_item_t expected_rows[$];
  int items_seen;
  int results_seen;
  int rows_seen;
  int redraws_seen;
  int errors;

  function new();
    foreach (page_mem[i]) page_mem[i] = 8'h00;
    video_mode   = tmcr_pkg::MODE_TEXT;
    cursor_col   = '0;
    cursor_row   = '0;
    blink_phase  = 1'b0;
    double_scale = 1'b0;
    offset_x     = '0;
    offset_y     = '0;
  endfunction

  function int pending();
    return expected_rows.size();
  endfunction

  function void write_reg(tmcr_pkg::cfg_reg_e idx, logic [9:0] val);
    case (idx)
      tmcr_pkg::CFG_VIDEO_MODE:   video_mode   = val[1:0];
      tmcr_pkg::CFG_CURSOR_COL:   cursor_col   = val[6:0];
      tmcr_pkg::CFG_CURSOR_ROW:   cursor_row   = val[4:0];
      tmcr_pkg::CFG_BLINK_PHASE:  blink_phase  = val[0];
      tmcr_pkg::CFG_DOUBLE_SCALE: double_scale = val[0];
      tmcr_pkg::CFG_OFFSET_X:     offset_x     = val;
      tmcr_pkg::CFG_OFFSET_Y:     offset_y     = val;
      default: ;
    endcase
  endfunction

  // glyph rows of one cell, as the page stands now
  function void predict_cell(int unsigned col, int unsigned row);
    int unsigned base;
    int unsigned px;
    int unsigned py;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [7:0]  bits;
    logic [7:0]  gb;
    logic [7:0]  rb;
    logic [3:0]  idx;
    logic        inv;
    logic        on_cursor;
    logic [23:0] shade [8];
    tmcr_pkg::out_item_t r;
    base = (2 * (COLS * row + col)) & 32'h1FFF;
    ch   = page_mem[base];
    attr = page_mem[(base + 1) & 32'h1FFF];
    on_cursor = (cursor_col == col) && (cursor_row == row);
    for (int y = 0; y < GLYPH_H; y++) begin
      bits = page_mem[(tmcr_pkg::FONT_BASE + 16 * ch + y) & 32'h1FFF];
      inv  = on_cursor && (y >= GLYPH_H - 2) && blink_phase;
      py   = GLYPH_H * row + y;
      if (double_scale) begin
        px = 16 * col;
        py = 2 * py;
      end else begin
        px = 8 * col + offset_x;
        py = py + offset_y;
      end
      for (int x = 0; x < 8; x++) begin
        idx = (bits[7 - x] ^ inv) ? attr[3:0] : attr[7:4];
        gb  = page_mem[tmcr_pkg::PAL_BASE + 2 * idx];
        rb  = page_mem[tmcr_pkg::PAL_BASE + 2 * idx + 1];
        shade[x] = {rb[3:0], 4'h0, gb[7:4], 4'h0, gb[3:0], 4'h0};
      end
      r         = '0;
      r.kind    = tmcr_pkg::KIND_GLYPH;
      r.pixel_x = px[10:0];
      r.pixel_y = py[10:0];
      r.color0  = shade[0];
      r.color1  = shade[1];
      r.color2  = shade[2];
      r.color3  = shade[3];
      r.color4  = shade[4];
      r.color5  = shade[5];
      r.color6  = shade[6];
      r.color7  = shade[7];
      r.last    = (y == GLYPH_H - 1);
      expected_rows.push_back(r);
    end
  endfunction

  function void note_item(tmcr_pkg::in_item_t it);
    tmcr_pkg::out_item_t r;
    items_seen++;
    if (it.action == tmcr_pkg::ACT_WRITE) begin
      page_mem[it.addr] = it.data;
      if (video_mode != tmcr_pkg::MODE_TEXT) return;
      if (it.addr < 2 * COLS * LINES && it.addr < tmcr_pkg::PAL_BASE) begin
        predict_cell((it.addr >> 1) % COLS, (it.addr >> 1) / COLS);
      end else if ((it.addr >= tmcr_pkg::PAL_BASE && it.addr < tmcr_pkg::PAL_END) ||
                   it.addr >= tmcr_pkg::FONT_BASE) begin
        r      = '0;
        r.kind = tmcr_pkg::KIND_REDRAW;
        r.last = 1'b1;
        expected_rows.push_back(r);
      end
    end else if (video_mode == tmcr_pkg::MODE_TEXT) begin
      predict_cell(it.cell_col, it.cell_row);
    end
  endfunction

  function void check_result(tmcr_pkg::out_item_t got);
    tmcr_pkg::out_item_t want;
    logic bad;
    results_seen++;
    if (got.kind == tmcr_pkg::KIND_REDRAW) redraws_seen++;
    else rows_seen++;
    if (expected_rows.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("result %0d arrived with nothing expected: %p", results_seen, got);
      return;
    end
    want = expected_rows.pop_front();
    bad = (got.kind !== want.kind) || (got.pixel_x !== want.pixel_x) ||
          (got.pixel_y !== want.pixel_y) || (got.last !== want.last) ||
          (got.color0 !== want.color0) || (got.color1 !== want.color1) ||
          (got.color2 !== want.color2) || (got.color3 !== want.color3) ||
          (got.color4 !== want.color4) || (got.color5 !== want.color5) ||
          (got.color6 !== want.color6) || (got.color7 !== want.color7);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d mismatch (exp/got): kind %0d/%0d x %0d/%0d y %0d/%0d last %0d/%0d",
                 results_seen, want.kind, got.kind, want.pixel_x, got.pixel_x,
                 want.pixel_y, got.pixel_y, want.last, got.last);
        $display("  exp colors %h %h %h %h %h %h %h %h", want.color0, want.color1,
                 want.color2, want.color3, want.color4, want.color5, want.color6,
                 want.color7);
        $display("  got colors %h %h %h %h %h %h %h %h", got.color0, got.color1,
                 got.color2, got.color3, got.color4, got.color5, got.color6,
                 got.color7);
      end
    end
  endfunction
endclass

module tb_text_mode_cell_renderer_top;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic out_ready = 1'b0;
  logic calm      = 1'b0;

  logic [6:0] cur_col;
  logic [4:0] cur_row;
  logic       text_on;

  text_page_scoreboard sb;

  tmcr_stream_if #(.T(tmcr_pkg::in_item_t))  in_if ();
  tmcr_stream_if #(.T(tmcr_pkg::out_item_t)) out_if ();
  tmcr_stream_if #(.T(tmcr_pkg::cfg_wr_t))   cfg_if ();

  assign out_if.ready = out_ready;

  text_mode_cell_renderer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  initial begin
    #3_000_000;
    $display("timeout: %0d results still outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(tmcr_pkg::in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 38) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(it);
  endtask

  task automatic input_quiet();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic hold_until_drained();
    input_quiet();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(tmcr_pkg::cfg_reg_e idx, logic [9:0] val);
    tmcr_pkg::cfg_wr_t w;
    w.idx   = idx;
    w.wdata = val;
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(logic [1:0] mode, logic [6:0] ccol, logic [4:0] crow,
                            logic blink, logic dbl, logic [9:0] ox, logic [9:0] oy);
    cfg_write(tmcr_pkg::CFG_VIDEO_MODE, {8'h00, mode});
    cfg_write(tmcr_pkg::CFG_CURSOR_COL, {3'b000, ccol});
    cfg_write(tmcr_pkg::CFG_CURSOR_ROW, {5'b00000, crow});
    cfg_write(tmcr_pkg::CFG_BLINK_PHASE, {9'h000, blink});
    cfg_write(tmcr_pkg::CFG_DOUBLE_SCALE, {9'h000, dbl});
    cfg_write(tmcr_pkg::CFG_OFFSET_X, ox);
    cfg_write(tmcr_pkg::CFG_OFFSET_Y, oy);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cur_col = ccol;
    cur_row = crow;
    text_on = (mode == tmcr_pkg::MODE_TEXT);
  endtask

  function automatic tmcr_pkg::in_item_t noise_item();
    tmcr_pkg::in_item_t it;
    it.action   = tmcr_pkg::ACT_WRITE;
    it.addr     = 13'($urandom_range(8191));
    it.data     = 8'($urandom_range(255));
    it.cell_col = 7'($urandom_range(127));
    it.cell_row = 5'($urandom_range(31));
    return it;
  endfunction

  task automatic write_byte(logic [12:0] addr, logic [7:0] data);
    tmcr_pkg::in_item_t it;
    it      = noise_item();
    it.addr = addr;
    it.data = data;
    send_item(it);
  endtask

  task automatic render_at(logic [6:0] col, logic [4:0] row);
    tmcr_pkg::in_item_t it;
    it          = noise_item();
    it.action   = tmcr_pkg::ACT_RENDER;
    it.cell_col = col;
    it.cell_row = row;
    send_item(it);
  endtask

  // a handful of glyphs gets most of the font and character traffic
  function automatic logic [7:0] pick_glyph();
    case ($urandom_range(4))
      0: return 8'h00;
      1: return 8'h41;
      2: return 8'h7F;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic tmcr_pkg::in_item_t random_item();
    tmcr_pkg::in_item_t it;
    int q;
    it = noise_item();
    q  = $urandom_range(99);
    if ($urandom_range(99) < 35) begin
      it.action = tmcr_pkg::ACT_RENDER;
      if (q < 20) begin
        it.cell_col = cur_col;
        it.cell_row = cur_row;
      end else if (q < 90) begin
        it.cell_col = 7'($urandom_range(79));
        it.cell_row = 5'($urandom_range(24));
      end
    end else if (q < 30) begin
      it.addr = 13'($urandom_range(3999));
      if (!it.addr[0] && $urandom_range(99) < 60) it.data = pick_glyph();
    end else if (q < 50) begin
      it.addr = tmcr_pkg::PAL_BASE + 13'($urandom_range(31));
    end else if (q < 75) begin
      it.addr = tmcr_pkg::FONT_BASE + {1'b0, pick_glyph(), 4'h0} + 13'($urandom_range(15));
    end else if (q < 85) begin
      it.addr = tmcr_pkg::PAL_END + 13'($urandom_range(63));
    end
    return it;
  endfunction

  initial begin
    int n;
    int text_items;
    tmcr_pkg::in_item_t it;
    sb = new();
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    cur_col        = '0;
    cur_row        = '0;
    text_on        = 1'b1;
    text_items     = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    set_config(tmcr_pkg::MODE_TEXT, 7'd0, 5'd0, 1'b1, 1'b0, 10'd0, 10'd0);

    // blank page first: cell 0 is the cursor cell, all colors zero
    render_at(7'd0, 5'd0);
    write_byte(13'h0FA0, 8'h5A);
    write_byte(13'h0FA1, 8'hFF);
    write_byte(13'h0FBE, 8'hFF);
    write_byte(13'h0FBF, 8'h0C);
    write_byte(tmcr_pkg::FONT_BASE + 13'h0410, 8'h81);
    write_byte(tmcr_pkg::FONT_BASE + 13'h041F, 8'hFF);
    write_byte(13'h1FFF, 8'hA5);
    write_byte(13'h1FF0, 8'hFF);
    write_byte(13'h0000, 8'h41);
    write_byte(13'h0001, 8'hF0);
    write_byte(13'h0F9E, 8'hFF);
    write_byte(13'h0F9F, 8'h0F);
    write_byte(13'h0FC0, 8'h12);
    write_byte(13'h0FFF, 8'h34);
    render_at(7'd79, 5'd24);
    render_at(7'd127, 5'd31);
    render_at(7'd80, 5'd0);
    render_at(7'd0, 5'd0);
    render_at(7'd5, 5'd3);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 1);
      case (ph)
        0: set_config(tmcr_pkg::MODE_TEXT, 7'd79, 5'd24, 1'b1, 1'b0, 10'd1023, 10'd1023);
        1: set_config(tmcr_pkg::MODE_TEXT, 7'd0, 5'd0, 1'b0, 1'b1, 10'd0, 10'd0);
        2: set_config(2'd3, 7'($urandom_range(79)), 5'($urandom_range(24)), 1'b1,
                      1'b0, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
        3: set_config(tmcr_pkg::MODE_TEXT, 7'($urandom_range(79)),
                      5'($urandom_range(24)), 1'b1,
                      1'b1, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
        4: set_config(tmcr_pkg::MODE_TEXT, 7'($urandom_range(79)),
                      5'($urandom_range(24)), 1'b1,
                      1'b0, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
        5: set_config(2'($urandom_range(1, 2)), 7'd40, 5'd12, 1'b0, 1'b1,
                      10'd512, 10'd256);
        6: set_config(tmcr_pkg::MODE_TEXT, 7'($urandom_range(79)), 5'($urandom_range(24)),
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      10'($urandom_range(1023)), 10'($urandom_range(1023)));
        default: set_config(tmcr_pkg::MODE_TEXT, 7'($urandom_range(79)),
                            5'($urandom_range(24)), 1'b1, 1'b0, 10'd0, 10'd0);
      endcase
      n = text_on ? 30 : 10;
      for (int i = 0; i < n; i++) begin
        if (text_on && i == n / 2) hold_until_drained();
        it = random_item();
        send_item(it);
      end
      if (text_on) text_items += n;
      settle();
    end
    calm = 1'b0;

    $display("%0d items (%0d random in text mode) over 9 register settings",
             sb.items_seen, text_items);
    $display("%0d glyph rows and %0d redraw requests checked, %0d mismatches",
             sb.rows_seen, sb.redraws_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d expected results never arrived", sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
